// ===== sv/mmb_pkg.sv =====
// Package for the matrix multiply with bias block: field widths, item kinds,
// register indexes and the command and status structs between controller
// and datapath. No dependencies.
`timescale 1ns / 1ps

package mmb_pkg;

  localparam int KIND_W    = 2;
  localparam int INDEX_W   = 10;
  localparam int VALUE_W   = 16;
  localparam int COL_W     = 4;
  localparam int ACC_W     = 48;
  localparam int PROD_W    = 32;
  localparam int ROWS_W    = 5;
  localparam int INNER_W   = 7;
  localparam int COLS_W    = 5;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;

  // Item kinds on the input channel.
  localparam logic [KIND_W-1:0] KIND_LEFT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RIGHT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BIAS  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ROW   = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ROWS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_EN  = 2'd3;

  localparam logic [ROWS_W-1:0]  ROWS_RESET  = 5'd16;
  localparam logic [INNER_W-1:0] INNER_RESET = 7'd64;
  localparam logic [COLS_W-1:0]  COLS_RESET  = 5'd16;

  typedef struct packed {
    logic             rd;        // read one left and one right element
    logic             first;     // first product of a column: load accumulator
    logic             last;      // last product of a column
    logic             wr_left;
    logic             wr_right;
    logic             wr_bias;
    logic             finish;    // round the accumulator into the output register
    logic             bias_en;
    logic [COL_W-1:0] col;
    logic             col_last;
  } mmb_cmd_t;

  typedef struct packed {
    logic acc_done;  // accumulator holds a complete column sum
    logic out_free;  // output register can take a new result this cycle
  } mmb_status_t;

endpackage

// ===== sv/mmb_in_if.sv =====
// Input channel of the matrix multiply with bias block: valid/ready plus
// the item fields. Depends on nothing.
`timescale 1ns / 1ps

interface mmb_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [9:0]         index;
  logic signed [15:0] value;

  modport source (output valid, output kind, output index, output value, input ready);
  modport sink   (input valid, input kind, input index, input value, output ready);
endinterface

// ===== sv/mmb_out_if.sv =====
// Result channel of the matrix multiply with bias block: valid/ready plus
// the result fields. Depends on nothing.
`timescale 1ns / 1ps

interface mmb_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] result;
  logic [3:0]         col;
  logic               last;
  logic               saturated;

  modport source (output valid, output result, output col, output last, output saturated,
                  input ready);
  modport sink   (input valid, input result, input col, input last, input saturated,
                  output ready);
endinterface

// ===== sv/mmb_dpath.sv =====
// Datapath of the matrix multiply with bias block: the three stores, the
// multiply-accumulate pipeline, rounding and the output register. Uses mmb_pkg.
`timescale 1ns / 1ps

module mmb_dpath
  import mmb_pkg::*;
#(
  parameter int MAX_ROWS  = 16,
  parameter int MAX_INNER = 64,
  parameter int MAX_COLS  = 16,
  localparam int LEFT_DEPTH  = MAX_ROWS * MAX_INNER,
  localparam int RIGHT_DEPTH = MAX_INNER * MAX_COLS,
  localparam int LAW = (LEFT_DEPTH > 1) ? $clog2(LEFT_DEPTH) : 1,
  localparam int RAW = (RIGHT_DEPTH > 1) ? $clog2(RIGHT_DEPTH) : 1,
  localparam int BAW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  mmb_cmd_t                  cmd,
  output mmb_status_t               st,
  input  logic [LAW-1:0]            left_addr,
  input  logic [RAW-1:0]            right_addr,
  input  logic [BAW-1:0]            bias_addr,
  input  logic signed [VALUE_W-1:0] wr_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [VALUE_W-1:0] out_result,
  output logic [COL_W-1:0]          out_col,
  output logic                      out_last,
  output logic                      out_sat
);

  logic signed [VALUE_W-1:0] left_mem  [LEFT_DEPTH];
  logic signed [VALUE_W-1:0] right_mem [RIGHT_DEPTH];
  logic signed [VALUE_W-1:0] bias_mem  [MAX_COLS];

  logic signed [VALUE_W-1:0] a_q_r, b_q_r, bias_q_r;
  logic                      s1_v_r, s1_first_r, s1_last_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic                      s2_v_r, s2_first_r, s2_last_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic                      acc_done_r;

  logic                      out_valid_r, out_valid_nxt;
  logic signed [VALUE_W-1:0] out_result_r;
  logic [COL_W-1:0]          out_col_r;
  logic                      out_last_r, out_sat_r;

  logic signed [ACC_W-1:0]   addend;
  logic signed [ACC_W-1:0]   fin_sum;
  logic [ACC_W-13:0]         quot;
  logic                      pos_ovf, neg_ovf;
  logic signed [VALUE_W-1:0] fin_result;

  // Single-port stores: a write takes the port, otherwise a read may.
  always_ff @(posedge clk) begin
    if (cmd.wr_left) begin
      left_mem[left_addr] <= wr_data;
    end else if (cmd.rd) begin
      a_q_r <= left_mem[left_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_right) begin
      right_mem[right_addr] <= wr_data;
    end else if (cmd.rd) begin
      b_q_r <= right_mem[right_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_bias) begin
      bias_mem[bias_addr] <= wr_data;
    end else if (cmd.rd && cmd.first) begin
      bias_q_r <= bias_mem[bias_addr];
    end
  end

  // Multiply stage, then accumulate stage.
  always_ff @(posedge clk) begin
    prod_r <= a_q_r * b_q_r;
    if (s2_v_r) begin
      acc_r <= s2_first_r ? ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r     <= 1'b0;
      s1_first_r <= 1'b0;
      s1_last_r  <= 1'b0;
      s2_v_r     <= 1'b0;
      s2_first_r <= 1'b0;
      s2_last_r  <= 1'b0;
      acc_done_r <= 1'b0;
    end else begin
      s1_v_r     <= cmd.rd;
      s1_first_r <= cmd.first;
      s1_last_r  <= cmd.last;
      s2_v_r     <= s1_v_r;
      s2_first_r <= s1_first_r;
      s2_last_r  <= s1_last_r;
      acc_done_r <= s2_v_r && s2_last_r;
    end
  end

  // The bias sits at bit 12 and the rounding half at bit 11, so both fold
  // into one addend.
  always_comb begin
    if (cmd.bias_en) begin
      addend = {{(ACC_W-VALUE_W-12){bias_q_r[VALUE_W-1]}}, bias_q_r, 12'h800};
    end else begin
      addend = ACC_W'(2048);
    end
    fin_sum = acc_r + addend;
    quot    = fin_sum[ACC_W-1:12];
    pos_ovf = !quot[ACC_W-13] && (|quot[ACC_W-14:VALUE_W-1]);
    neg_ovf = quot[ACC_W-13] && !(&quot[ACC_W-14:VALUE_W-1]);
    if (pos_ovf) begin
      fin_result = 16'sh7FFF;
    end else if (neg_ovf) begin
      fin_result = -16'sh8000;
    end else begin
      fin_result = quot[VALUE_W-1:0];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_result_r <= fin_result;
      out_col_r    <= cmd.col;
      out_last_r   <= cmd.col_last;
      out_sat_r    <= pos_ovf || neg_ovf;
    end
  end

  assign st.acc_done = acc_done_r;
  assign st.out_free = !out_valid_r || out_ready;

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;
  assign out_col    = out_col_r;
  assign out_last   = out_last_r;
  assign out_sat    = out_sat_r;

endmodule

// ===== sv/mmb_ctrl.sv =====
// Controller of the matrix multiply with bias block: configuration registers,
// load decoding, the column and inner-loop sequencer and store addresses.
// Uses mmb_pkg; drives mmb_dpath through mmb_cmd_t.
`timescale 1ns / 1ps

module mmb_ctrl
  import mmb_pkg::*;
#(
  parameter int MAX_ROWS  = 16,
  parameter int MAX_INNER = 64,
  parameter int MAX_COLS  = 16,
  localparam int LEFT_DEPTH  = MAX_ROWS * MAX_INNER,
  localparam int RIGHT_DEPTH = MAX_INNER * MAX_COLS,
  localparam int LAW = (LEFT_DEPTH > 1) ? $clog2(LEFT_DEPTH) : 1,
  localparam int RAW = (RIGHT_DEPTH > 1) ? $clog2(RIGHT_DEPTH) : 1,
  localparam int BAW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [KIND_W-1:0]     in_kind,
  input  logic [INDEX_W-1:0]    in_index,
  output mmb_cmd_t              cmd,
  input  mmb_status_t           st,
  output logic [LAW-1:0]        left_addr,
  output logic [RAW-1:0]        right_addr,
  output logic [BAW-1:0]        bias_addr
);

  localparam int MW = $clog2(MAX_ROWS + 1);
  localparam int KW = $clog2(MAX_INNER + 1);
  localparam int NW = $clog2(MAX_COLS + 1);
  localparam int TW = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
  localparam int JW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_MAC   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_FIN   = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  logic [ROWS_W-1:0]  rows_r;
  logic [INNER_W-1:0] inner_r;
  logic [COLS_W-1:0]  cols_r;
  logic               bias_en_r;
  logic [TW-1:0]      t_r, t_nxt;
  logic [JW-1:0]      j_r, j_nxt;
  logic [LAW-1:0]     lptr_r, lptr_nxt;
  logic [RAW-1:0]     rptr_r, rptr_nxt;
  logic [LAW-1:0]     row_base_r, row_base_nxt;

  logic [MW-1:0]      m_w;
  logic [KW-1:0]      k_w;
  logic [NW-1:0]      n_w;
  logic [MW+KW-1:0]   mk_w;
  logic [KW+NW-1:0]   kn_w;
  logic               accept;
  logic               t_last, j_last;

  // A dimension of zero acts as one; above the build maximum it acts as the maximum.
  always_comb begin
    if (rows_r == '0) begin
      m_w = MW'(1);
    end else if (32'(rows_r) > MAX_ROWS) begin
      m_w = MW'(MAX_ROWS);
    end else begin
      m_w = MW'(rows_r);
    end
    if (inner_r == '0) begin
      k_w = KW'(1);
    end else if (32'(inner_r) > MAX_INNER) begin
      k_w = KW'(MAX_INNER);
    end else begin
      k_w = KW'(inner_r);
    end
    if (cols_r == '0) begin
      n_w = NW'(1);
    end else if (32'(cols_r) > MAX_COLS) begin
      n_w = NW'(MAX_COLS);
    end else begin
      n_w = NW'(cols_r);
    end
    mk_w = (MW+KW)'(m_w) * (MW+KW)'(k_w);
    kn_w = (KW+NW)'(k_w) * (KW+NW)'(n_w);
  end

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign t_last   = (32'(t_r) + 32'd1 == 32'(k_w));
  assign j_last   = (32'(j_r) + 32'd1 == 32'(n_w));

  always_comb begin
    state_nxt    = state_r;
    t_nxt        = t_r;
    j_nxt        = j_r;
    lptr_nxt     = lptr_r;
    rptr_nxt     = rptr_r;
    row_base_nxt = row_base_r;
    cmd          = '0;
    cmd.bias_en  = bias_en_r;
    cmd.col      = COL_W'(j_r);
    cmd.col_last = j_last;
    left_addr    = lptr_r;
    right_addr   = rptr_r;
    bias_addr    = BAW'(j_r);
    case (state_r)
      S_IDLE: begin
        left_addr  = LAW'(in_index);
        right_addr = RAW'(in_index);
        bias_addr  = BAW'(in_index);
        if (accept) begin
          case (in_kind)
            KIND_LEFT:  cmd.wr_left  = (32'(in_index) < 32'(mk_w));
            KIND_RIGHT: cmd.wr_right = (32'(in_index) < 32'(kn_w));
            KIND_BIAS:  cmd.wr_bias  = (32'(in_index) < 32'(n_w));
            KIND_ROW: begin
              if (32'(in_index) < 32'(m_w)) begin
                row_base_nxt = LAW'(32'(in_index) * 32'(k_w));
                lptr_nxt     = LAW'(32'(in_index) * 32'(k_w));
                rptr_nxt     = '0;
                t_nxt        = '0;
                j_nxt        = '0;
                state_nxt    = S_MAC;
              end
            end
            default: ;
          endcase
        end
      end
      S_MAC: begin
        cmd.rd    = 1'b1;
        cmd.first = (t_r == '0);
        cmd.last  = t_last;
        lptr_nxt  = lptr_r + 1'b1;
        rptr_nxt  = RAW'(32'(rptr_r) + 32'(n_w));
        t_nxt     = t_r + 1'b1;
        if (t_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (st.acc_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // Waits here while the previous result still waits in the output register.
        if (st.out_free) begin
          cmd.finish = 1'b1;
          if (j_last) begin
            state_nxt = S_IDLE;
          end else begin
            j_nxt     = j_r + 1'b1;
            t_nxt     = '0;
            lptr_nxt  = row_base_r;
            rptr_nxt  = RAW'(32'(j_r) + 32'd1);
            state_nxt = S_MAC;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      rows_r    <= ROWS_RESET;
      inner_r   <= INNER_RESET;
      cols_r    <= COLS_RESET;
      bias_en_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          REG_ROWS:    rows_r    <= cfg_wdata[ROWS_W-1:0];
          REG_INNER:   inner_r   <= cfg_wdata[INNER_W-1:0];
          REG_COLS:    cols_r    <= cfg_wdata[COLS_W-1:0];
          REG_BIAS_EN: bias_en_r <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    t_r        <= t_nxt;
    j_r        <= j_nxt;
    lptr_r     <= lptr_nxt;
    rptr_r     <= rptr_nxt;
    row_base_r <= row_base_nxt;
  end

  // A column sum completes only after its last read, while waiting for it.
  a_done_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    st.acc_done |-> (state_r == S_DRAIN))
    else $error("accumulator finished outside the drain state");

  // A result is only rounded into the output register when it can be taken.
  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> st.out_free)
    else $error("result written over a held output item");

  // The inner counter never runs past the inner length.
  a_inner_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MAC) |-> (32'(t_r) < 32'(k_w)))
    else $error("inner counter out of range");

  // After the last column of a row the controller is back to taking items.
  a_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && cmd.col_last) |=> (state_r == S_IDLE))
    else $error("row did not end after its last column");

endmodule

// ===== sv/matrix_multiply_bias_core.sv =====
// Top level of the matrix multiply with bias block: computes one output row
// of A times B, plus bias when enabled, in signed Q4.12. Uses mmb_pkg, mmb_in_if, mmb_out_if,
// mmb_ctrl and mmb_dpath.
//
// Usage:
//   in_ch carries items: kind 0, 1 and 2 write an element of A, of B or of the
//   bias vector at index (ignored when the index is out of range for the
//   current dimensions); kind 3 computes row index of the output.
//   out_ch carries one result per column of a row item, in column order,
//   with last set on the final column and saturated set when clamping acted.
//   cfg_we/cfg_idx/cfg_wdata write rows_in_use, inner_len, cols_in_use and
//   bias_enable; the user must write them only while the block is idle, as the block does not check this.
// Timing: a load item is written into its store when it is accepted. In a row
//   item each column is inner reads through the single multiply-accumulate
//   unit, then the read, multiply and accumulate stages and a rounding
//   step. No item is taken while a row is busy.
// Reset: control state clears and the registers return to 16, 64, 16, 0;
//   store contents are undefined until written.
// Stall: a result waits in the output register; the next column is summed
//   meanwhile and held back until the receiver takes the waiting item.
`timescale 1ns / 1ps

module matrix_multiply_bias_core
  import mmb_pkg::*;
#(
  parameter int MAX_ROWS  = 16,
  parameter int MAX_INNER = 64,
  parameter int MAX_COLS  = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata,
  mmb_in_if.sink               in_ch,
  mmb_out_if.source            out_ch
);

  localparam int LEFT_DEPTH  = MAX_ROWS * MAX_INNER;
  localparam int RIGHT_DEPTH = MAX_INNER * MAX_COLS;
  localparam int LAW = (LEFT_DEPTH > 1) ? $clog2(LEFT_DEPTH) : 1;
  localparam int RAW = (RIGHT_DEPTH > 1) ? $clog2(RIGHT_DEPTH) : 1;
  localparam int BAW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  mmb_cmd_t       cmd;
  mmb_status_t    st;
  logic [LAW-1:0] left_addr;
  logic [RAW-1:0] right_addr;
  logic [BAW-1:0] bias_addr;

  mmb_ctrl #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_INNER (MAX_INNER),
    .MAX_COLS  (MAX_COLS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_kind    (in_ch.kind),
    .in_index   (in_ch.index),
    .cmd        (cmd),
    .st         (st),
    .left_addr  (left_addr),
    .right_addr (right_addr),
    .bias_addr  (bias_addr)
  );

  mmb_dpath #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_INNER (MAX_INNER),
    .MAX_COLS  (MAX_COLS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .left_addr  (left_addr),
    .right_addr (right_addr),
    .bias_addr  (bias_addr),
    .wr_data    (in_ch.value),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_result (out_ch.result),
    .out_col    (out_ch.col),
    .out_last   (out_ch.last),
    .out_sat    (out_ch.saturated)
  );

endmodule
